// ===== rtl/crgm_pkg.sv =====
// Package for the color ramp gradient map unit.
// Holds sizes, register indexes and the stop word layout.
// No dependencies.
package crgm_pkg;

    localparam int MAX_STOPS      = 7;
    localparam int STOP_REGS      = 7;
    localparam int STOP_IDX_W     = $clog2(STOP_REGS);
    localparam int COUNT_W        = 3;
    localparam int LEVEL_W        = 8;
    localparam int CHAN_W         = 8;
    localparam int NUM_CHAN       = 3;
    localparam int COLOR_W        = CHAN_W * NUM_CHAN;
    localparam int STOP_W         = 32;
    localparam int NUM_W          = 2 * CHAN_W;
    localparam int DIV_STAGES     = 4;
    localparam int BITS_PER_STAGE = CHAN_W / DIV_STAGES;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STOP_BASE  = CFG_IDX_W'(1);

    typedef struct packed {
        logic [LEVEL_W-1:0] pos;
        logic [COLOR_W-1:0] color;
    } stop_t;

endpackage

// ===== rtl/color_ramp_gradient_map_unit.sv =====
// Top level of the color ramp gradient map unit: stop lookup, channel
// products and a pipelined restoring divider.
// Depends on crgm_pkg.
//
//  channel   | direction | payload (lowest bits first)
//  s_*       | in        | tdata: level[7:0]
//  m_*       | out       | tdata: red[7:0], green[15:8], blue[23:16]
//  cfg_*     | in        | write enable, register index, 32-bit write data
//
// One word per cycle while the output is not stalled. A word passes through
// the lookup stage, the product stage and four divider stages of two
// quotient bits each. A stall on the output holds every stage in place;
// s_tready follows m_tready while the output register is full.
// Reset clears the stop registers, the stop count and all valid bits.
module color_ramp_gradient_map_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [crgm_pkg::LEVEL_W-1:0]       s_tdata,   // level
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [crgm_pkg::COLOR_W-1:0]       m_tdata,   // red, green, blue
    input  logic                               cfg_wr_en,
    input  logic [crgm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [crgm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW = crgm_pkg::CHAN_W;
    localparam int NC = crgm_pkg::NUM_CHAN;
    localparam int DS = crgm_pkg::DIV_STAGES;

    // configuration
    logic [crgm_pkg::COUNT_W-1:0] stop_count_reg;
    crgm_pkg::stop_t              stop_reg [crgm_pkg::STOP_REGS];
    logic [crgm_pkg::CFG_IDX_W-1:0] stop_wr_idx;

    assign stop_wr_idx = cfg_index - crgm_pkg::REG_STOP_BASE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= '0;
            for (int i = 0; i < crgm_pkg::STOP_REGS; i++)
            begin
                stop_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == crgm_pkg::REG_STOP_COUNT)
            begin
                stop_count_reg <= cfg_data[crgm_pkg::COUNT_W-1:0];
            end
            else
            begin
                stop_reg[stop_wr_idx[crgm_pkg::STOP_IDX_W-1:0]] <=
                    crgm_pkg::stop_t'(cfg_data[crgm_pkg::STOP_W-1:0]);
            end
        end
    end

    logic pipe_en;
    logic [DS:0] dvalid_reg;

    assign pipe_en  = !m_tvalid || m_tready;
    assign s_tready = pipe_en;

    // stage 1: lookup
    logic [crgm_pkg::COUNT_W-1:0]    n_used;
    logic                            hit;
    logic [crgm_pkg::STOP_IDX_W-1:0] found;
    logic [crgm_pkg::STOP_IDX_W-1:0] prev_idx;
    logic [crgm_pkg::STOP_IDX_W-1:0] last_idx;
    logic [crgm_pkg::COLOR_W-1:0]    c0_next, c1_next;
    logic [CW-1:0]                   w0_next, w1_next, d1_next;

    always_comb
    begin
        n_used = (stop_count_reg > crgm_pkg::COUNT_W'(crgm_pkg::MAX_STOPS)) ?
                 crgm_pkg::COUNT_W'(crgm_pkg::MAX_STOPS) : stop_count_reg;
        hit   = 1'b0;
        found = '0;
        for (int i = 0; i < crgm_pkg::STOP_REGS; i++)
        begin
            if (!hit && (crgm_pkg::COUNT_W'(i) < n_used) && (stop_reg[i].pos >= s_tdata))
            begin
                hit   = 1'b1;
                found = crgm_pkg::STOP_IDX_W'(i);
            end
        end
        prev_idx = found - crgm_pkg::STOP_IDX_W'(1);
        last_idx = crgm_pkg::STOP_IDX_W'(n_used - crgm_pkg::COUNT_W'(1));
        c0_next  = '0;
        c1_next  = '0;
        w0_next  = '0;
        w1_next  = CW'(1);
        d1_next  = CW'(1);
        if (n_used == '0)
        begin
            c1_next = '0;
        end
        else if (!hit)
        begin
            c1_next = stop_reg[last_idx].color;
        end
        else if (found == '0)
        begin
            c1_next = stop_reg[0].color;
        end
        else
        begin
            c0_next = stop_reg[prev_idx].color;
            c1_next = stop_reg[found].color;
            w0_next = stop_reg[found].pos - s_tdata;
            w1_next = s_tdata - stop_reg[prev_idx].pos;
            d1_next = stop_reg[found].pos - stop_reg[prev_idx].pos;
        end
    end

    logic                         v1_reg;
    logic [crgm_pkg::COLOR_W-1:0] c0_reg, c1_reg;
    logic [CW-1:0]                w0_reg, w1_reg, d1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            c0_reg <= c0_next;
            c1_reg <= c1_next;
            w0_reg <= w0_next;
            w1_reg <= w1_next;
            d1_reg <= d1_next;
        end
    end

    // stage 2: channel products, loaded as divider state
    logic [CW-1:0] rem_reg  [DS+1][NC];
    logic [CW-1:0] lowq_reg [DS+1][NC];
    logic [CW-1:0] d_reg    [DS+1];
    logic [crgm_pkg::NUM_W-1:0] num_next [NC];

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            num_next[c] =
                (crgm_pkg::NUM_W'(c0_reg[CW*(NC-1-c) +: CW]) * crgm_pkg::NUM_W'(w0_reg)) +
                (crgm_pkg::NUM_W'(c1_reg[CW*(NC-1-c) +: CW]) * crgm_pkg::NUM_W'(w1_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvalid_reg <= '0;
        end
        else if (pipe_en)
        begin
            dvalid_reg <= {dvalid_reg[DS-1:0], v1_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            d_reg[0] <= d1_reg;
            for (int c = 0; c < NC; c++)
            begin
                rem_reg[0][c]  <= num_next[c][crgm_pkg::NUM_W-1:CW];
                lowq_reg[0][c] <= num_next[c][CW-1:0];
            end
        end
    end

    // one restoring step: shift in the next numerator bit, subtract if it fits
    function automatic logic [2*CW-1:0] div_step(input logic [CW-1:0] rem,
                                                  input logic [CW-1:0] lowq,
                                                  input logic [CW-1:0] d);
        logic [CW:0]   t;
        logic          qbit;
        logic [CW-1:0] r;
        t    = {rem, lowq[CW-1]};
        qbit = (t >= {1'b0, d});
        r    = qbit ? CW'(t - {1'b0, d}) : t[CW-1:0];
        return {r, lowq[CW-2:0], qbit};
    endfunction

    // stages 3 to 6: divider, two quotient bits each
    for (genvar k = 0; k < DS; k++)
    begin : g_div
        logic [2*CW-1:0] st_next [NC];

        always_comb
        begin
            for (int c = 0; c < NC; c++)
            begin
                st_next[c] = {rem_reg[k][c], lowq_reg[k][c]};
                for (int b = 0; b < crgm_pkg::BITS_PER_STAGE; b++)
                begin
                    st_next[c] = div_step(st_next[c][2*CW-1:CW], st_next[c][CW-1:0], d_reg[k]);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                d_reg[k+1] <= d_reg[k];
                for (int c = 0; c < NC; c++)
                begin
                    rem_reg[k+1][c]  <= st_next[c][2*CW-1:CW];
                    lowq_reg[k+1][c] <= st_next[c][CW-1:0];
                end
            end
        end
    end

    assign m_tvalid = dvalid_reg[DS];
    assign m_tdata  = {lowq_reg[DS][2], lowq_reg[DS][1], lowq_reg[DS][0]};

    // checks
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> d1_reg != '0)
        else $error("zero divisor entered the divider");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_en && v1_reg |=> dvalid_reg[0])
        else $error("word lost between lookup and product stage");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dvalid_reg[2] |-> (rem_reg[2][0] < d_reg[2]) && (rem_reg[2][1] < d_reg[2]) &&
                          (rem_reg[2][2] < d_reg[2]))
        else $error("divider remainder not below divisor");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(dvalid_reg) && $stable(v1_reg))
        else $error("pipeline moved during a stall");

endmodule
